[src/h3mh_pkg.sv]
// Shared constants, types and helper functions for the H3 matrix hash unit.
package h3mh_pkg;

	// Matrix geometry
	localparam int NUM_FUNCS     = 4;
	localparam int ROWS_PER_FUNC = 64;
	localparam int LANES         = 8;
	localparam int LANE_W        = $clog2(LANES);
	localparam int STORE_DEPTH   = NUM_FUNCS * ROWS_PER_FUNC;
	localparam int NUM_GROUPS    = STORE_DEPTH / LANES;
	localparam int GRP_AW        = $clog2(NUM_GROUPS);
	localparam int GRP_PER_FUNC  = ROWS_PER_FUNC / LANES;
	localparam int GRP_W         = $clog2(GRP_PER_FUNC);

	// Item opcodes
	localparam logic FUNC_HASH  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef logic [63:0] word_t;
	typedef logic [1:0]  mode_t;

	// Mode codes: number of halvings of the row count
	localparam mode_t MODE_64 = 2'd0;
	localparam mode_t MODE_32 = 2'd1;
	localparam mode_t MODE_16 = 2'd2;
	localparam mode_t MODE_8  = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic             start;
		logic             wr_en;
		logic             rd_en;
		logic [GRP_W-1:0] rd_grp;
		logic             load_out;
	} h3mh_cmd_t;

	// Map the requested width to a mode
	function automatic mode_t mode_of(input logic [6:0] ob);
		mode_t m;
		if (ob <= 7'd8)
			m = MODE_8;
		else if (ob <= 7'd16)
			m = MODE_16;
		else if (ob <= 7'd32)
			m = MODE_32;
		else
			m = MODE_64;
		return m;
	endfunction

	// Rotate left by k bits
	function automatic word_t rotl(input word_t v, input logic [5:0] k);
		word_t r;
		r = (v << k) | (v >> (7'd64 - {1'b0, k}));
		return r;
	endfunction

	// Final xor-shift folding for reduced modes
	function automatic word_t fold(input word_t v, input mode_t m);
		word_t r;
		r = v;
		if (m >= MODE_32)
			r = r ^ (r >> 32);
		if (m >= MODE_16)
			r = r ^ (r >> 16);
		if (m >= MODE_8)
			r = r ^ (r >> 8);
		return r;
	endfunction

endpackage

[src/h3mh_ctrl.sv]
// Controller state machine: input/output handshake and row group sequencing.
module h3mh_ctrl
	import h3mh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      func,
	input  logic [6:0] out_bits,
	output logic      out_valid,
	input  logic      out_ready,
	output h3mh_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [GRP_W-1:0] grp_q;
	logic [GRP_W-1:0] last_grp_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.start    = accept && (func == FUNC_HASH);
		cmd.wr_en    = accept && (func == FUNC_WRITE);
		cmd.rd_en    = (state_q == ST_RUN);
		cmd.rd_grp   = grp_q;
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// State and group counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			grp_q      <= '0;
			last_grp_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						grp_q      <= '0;
						// 8, 4, 2 or 1 groups
						last_grp_q <= GRP_W'((GRP_PER_FUNC - 1) >> mode_of(out_bits));
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (grp_q == last_grp_q)
						state_q <= ST_DRAIN;
					else
						grp_q <= grp_q + 1'b1;
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// A pending output word is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// A hash word starts at group zero
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_RUN && grp_q == '0))
		else $error("hash did not start at group zero");

	// Group counter never passes the last group
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (grp_q <= last_grp_q))
		else $error("group counter overran");

endmodule

[src/h3mh_datapath.sv]
// Datapath: matrix memory with valid bits, group mixing, folding and output register.
module h3mh_datapath
	import h3mh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  h3mh_cmd_t  cmd,
	input  logic [6:0] out_bits,
	input  logic [1:0] func_index,
	input  word_t      key_value,
	input  logic [7:0] row_address,
	input  word_t      row_data,
	output word_t      hash_value
);

	// Matrix: one memory row holds the eight words of one group
	logic [LANES-1:0][63:0] mem_q [NUM_GROUPS];
	logic [LANES-1:0]       valid_q [NUM_GROUPS];

	logic [GRP_AW-1:0] wr_grp;
	logic [LANE_W-1:0] wr_lane;
	logic              wr_ok;
	logic [GRP_AW-1:0] rd_grp;

	logic [1:0]        fidx_q;
	logic              fidx_ok_q;
	word_t             key_q;
	mode_t             mode_q;
	word_t             res_q;
	word_t             hash_q;

	logic [LANES-1:0][63:0] rd_word_s1;
	logic [LANES-1:0]       rd_vld_s1;
	logic                   acc_en_s1;
	word_t                  mix;

	assign wr_ok   = (32'(row_address) < STORE_DEPTH);
	assign wr_grp  = GRP_AW'(row_address >> LANE_W);
	assign wr_lane = row_address[LANE_W-1:0];
	assign rd_grp  = GRP_AW'({fidx_q, cmd.rd_grp});

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok)
			mem_q[wr_grp][wr_lane] <= row_data;
		if (cmd.rd_en)
			rd_word_s1 <= mem_q[rd_grp];
	end

	// Per-word valid bits: unwritten words read as zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++)
				valid_q[g] <= '0;
			rd_vld_s1 <= '0;
			acc_en_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en && wr_ok)
				valid_q[wr_grp][wr_lane] <= 1'b1;
			if (cmd.rd_en)
				rd_vld_s1 <= fidx_ok_q ? valid_q[rd_grp] : '0;
			acc_en_s1 <= cmd.rd_en;
		end
	end

	// Item operands latched at start
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fidx_q    <= func_index;
			fidx_ok_q <= (32'(func_index) < NUM_FUNCS);
			key_q     <= key_value;
			mode_q    <= mode_of(out_bits);
		end
	end

	// XOR of the eight rotated key-and-row terms
	always_comb begin
		mix = '0;
		for (int k = 0; k < LANES; k++) begin
			if (rd_vld_s1[k])
				mix = mix ^ rotl(key_q & rd_word_s1[k], 6'(k));
		end
	end

	// Running result
	always_ff @(posedge clk) begin
		if (cmd.start)
			res_q <= '0;
		else if (acc_en_s1)
			res_q <= rotl(res_q ^ mix, 6'd8);
	end

	// Output register with folding
	always_ff @(posedge clk) begin
		if (cmd.load_out)
			hash_q <= fold(res_q, mode_q);
	end

	assign hash_value = hash_q;

	// A written in-range word is marked valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && wr_ok) |=> valid_q[$past(wr_grp)][$past(wr_lane)])
		else $error("written word not marked valid");

endmodule

[src/h3_matrix_hash_unit.sv]
// Sequence: a hash word is accepted, reads G row groups, drains, then loads the
// folded output register; G = 8, 4, 2 or 1 row groups for the 64, 32, 16 or 8-bit mode.
// The matrix read port delivers one group of eight rows per cycle; no new item is
// accepted until a hash word is loaded out, but a matrix write leaves input ready.
// Reset: arst_n clears control state and all matrix valid bits at once, so the
// matrix reads as zero; out_bits resets to 64.
module h3_matrix_hash_unit
	import h3mh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [1:0] func_index,
	input  word_t      key_value,
	input  logic [7:0] row_address,
	input  word_t      row_data,
	output logic       out_valid,
	input  logic       out_ready,
	output word_t      hash_value
);

	logic [6:0] out_bits_q;
	h3mh_cmd_t  cmd;

	// Width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_bits_q <= 7'd64;
		else if (cfg_wr_en)
			out_bits_q <= cfg_wr_data;
	end

	h3mh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_bits  (out_bits_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	h3mh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.out_bits    (out_bits_q),
		.func_index  (func_index),
		.key_value   (key_value),
		.row_address (row_address),
		.row_data    (row_data),
		.hash_value  (hash_value)
	);

endmodule
